### src/token_expiry_table_defines.svh
// Assertion helpers for the token expiry table RTL.
`ifndef TOKEN_EXPIRY_TABLE_DEFINES_SVH
`define TOKEN_EXPIRY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TET_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tet_pkg.sv
`timescale 1ns / 1ps

package tet_pkg;

    // Table geometry
    localparam int ENTRIES  = 64;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int KEY_W    = 64;
    localparam int TIME_W   = 31;
    localparam int EXP_W    = TIME_W + 1;
    localparam int CNT_W    = 7;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Command queue between front and back (depth is a power of two)
    localparam int CQ_DEPTH = 2;
    localparam int CQ_IDX_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // Time to live after reset
    localparam logic [TIME_W-1:0] TTL_RESET = TIME_W'(1);

    // Request codes on the input word
    localparam logic [1:0] REQ_GENERATE = 2'd0;
    localparam logic [1:0] REQ_RENEW    = 2'd1;
    localparam logic [1:0] REQ_COUNT    = 2'd2;

    // Status codes on the result word
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Classified operation handed to the back end
    typedef enum logic [1:0] {
        OP_GEN   = 2'd0,
        OP_RENEW = 2'd1,
        OP_COUNT = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [KEY_W-1:0]  token_key;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0] live_count;
        logic [1:0]       status;
    } rsp_t;

    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
    } cmd_t;

endpackage

### src/tet_front.sv
`timescale 1ns / 1ps

module tet_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  tet_pkg::req_t req,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output tet_pkg::cmd_t cmd
);
    import tet_pkg::*;

    cmd_t                cq_mem [CQ_DEPTH];
    logic [CQ_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] cnt_reg, cnt_next;
    cmd_t                cls_cmd;
    logic                push_ok;
    logic                pop_ok;

    // Classify the incoming word
    always_comb
    begin
        cls_cmd.key = req.token_key;
        cls_cmd.now = req.now;
        case (req.req_type)
            REQ_GENERATE: cls_cmd.op = OP_GEN;
            REQ_RENEW:    cls_cmd.op = OP_RENEW;
            REQ_COUNT:    cls_cmd.op = OP_COUNT;
            default:      cls_cmd.op = OP_NOP;
        endcase
    end

    assign full      = (cnt_reg == CQ_CNT_W'(CQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = cq_mem[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_valid && cmd_ready;

    // Queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok && !pop_ok)
            cnt_next = cnt_reg + 1'b1;
        else if (!push_ok && pop_ok)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
            cq_mem[wr_ptr_reg] <= cls_cmd;
    end

endmodule

### src/tet_back.sv
`timescale 1ns / 1ps
`include "token_expiry_table_defines.svh"

module tet_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tet_pkg::TIME_W-1:0]  ttl,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  tet_pkg::cmd_t               cmd,
    output logic                        rsp_valid,
    input  logic                        rsp_pop,
    output tet_pkg::rsp_t               rsp
);
    import tet_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    // Table storage
    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [EXP_W-1:0] exp_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              chk_reg, chk_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [KEY_W-1:0]  rd_key_reg;
    logic [EXP_W-1:0]  rd_exp_reg;
    logic              match_found_reg, match_found_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    logic              match_live_reg, match_live_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              ent_valid;
    logic              ent_live;
    logic              ent_hit;
    logic              ent_avail;
    logic              fin_go;
    logic              wr_en;
    logic              do_wr;
    logic [IDX_W-1:0]  wr_idx;
    rsp_t              fin_rsp;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Entry check on the word read last cycle
    assign ent_valid = valid_reg[idx_reg];
    assign ent_live  = ent_valid && (rd_exp_reg > {1'b0, now_reg});
    assign ent_hit   = chk_reg && ent_valid && (rd_key_reg == key_reg);
    assign ent_avail = chk_reg && !ent_live;

    // Final decision once the scan is complete
    always_comb
    begin
        do_wr   = 1'b0;
        wr_idx  = match_idx_reg;
        fin_rsp = '{live_count: '0, status: ST_DONE};
        case (op_reg)
            OP_GEN:
            begin
                if (match_found_reg)
                    do_wr = 1'b1;
                else if (free_found_reg)
                begin
                    do_wr  = 1'b1;
                    wr_idx = free_idx_reg;
                end
                else
                    fin_rsp.status = ST_FULL;
            end
            OP_RENEW:
            begin
                if (match_found_reg && match_live_reg)
                    do_wr = 1'b1;
                else
                    fin_rsp.status = ST_IGNORED;
            end
            OP_COUNT:
                fin_rsp.live_count = cnt_reg;
            default:
                fin_rsp = '{live_count: '0, status: ST_DONE};
        endcase
    end

    assign fin_go = (state_reg == S_FIN) && !rsp_valid_reg;
    assign wr_en  = fin_go && do_wr;

    // Sequencer and scan accumulators
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        exp_next         = exp_reg;
        addr_next        = addr_reg;
        chk_next         = (state_reg == S_SCAN);
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_live_next  = match_live_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        cnt_next         = cnt_reg;
        valid_next       = valid_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;

        // first matching and first reusable slot, saturating live count
        if (ent_hit && !match_found_reg)
        begin
            match_found_next = 1'b1;
            match_idx_next   = idx_reg;
            match_live_next  = ent_live;
        end
        if (ent_avail && !free_found_reg)
        begin
            free_found_next = 1'b1;
            free_idx_next   = idx_reg;
        end
        if (chk_reg && ent_live && (cnt_reg != COUNT_MAX))
            cnt_next = cnt_reg + 1'b1;

        if (rsp_valid_reg && rsp_pop)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next          = cmd.op;
                    key_next         = cmd.key;
                    now_next         = cmd.now;
                    exp_next         = {1'b0, cmd.now} + {1'b0, ttl};
                    addr_next        = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    cnt_next         = '0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_IDX)
                    state_next = S_LAST;
            end
            S_LAST:
                state_next = S_FIN;
            S_FIN:
            begin
                if (fin_go)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = fin_rsp;
                    state_next     = S_IDLE;
                    if (wr_en)
                        valid_next[wr_idx] = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            chk_reg         <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            valid_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            chk_reg         <= chk_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            valid_reg       <= valid_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        now_reg        <= now_next;
        exp_reg        <= exp_next;
        addr_reg       <= addr_next;
        idx_reg        <= addr_reg;
        match_idx_reg  <= match_idx_next;
        match_live_reg <= match_live_next;
        free_idx_reg   <= free_idx_next;
        cnt_reg        <= cnt_next;
        rsp_reg        <= rsp_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_idx] <= key_reg;
            exp_mem[wr_idx] <= exp_reg;
        end
        rd_key_reg <= key_mem[addr_reg];
        rd_exp_reg <= exp_mem[addr_reg];
    end

    `TET_ASSERT_NEXT(a_last_to_fin, state_reg == S_LAST, state_reg == S_FIN, "scan tail skipped")
    `TET_ASSERT_NEXT(a_fin_loads_rsp, fin_go, rsp_valid_reg && (state_reg == S_IDLE), "result lost")
    `TET_ASSERT_NOW(a_idle_no_check, state_reg == S_IDLE, !chk_reg, "stray entry check")
    `TET_ASSERT_NOW(a_renew_valid, wr_en && (op_reg == OP_RENEW), valid_reg[wr_idx], "renew on free slot")

endmodule

### src/token_expiry_table.sv
`timescale 1ns / 1ps
// Each accepted request scans all table entries through the single read port, one entry
// per cycle, then passes S_LAST and S_FIN, which loads the result once the previous
// result has been popped. The next request is taken only after that result is loaded.
// A two-word queue takes requests while the scan runs; results wait in an output register.
// Reset (rst_n, async, active low) empties all queues, marks every slot free and
// sets time_to_live to 1.

module token_expiry_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  tet_pkg::req_t               req,
    output logic                        empty,
    input  logic                        pop,
    output tet_pkg::rsp_t               rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tet_pkg::TIME_W-1:0]  cfg_data
);
    import tet_pkg::*;

    logic [TIME_W-1:0] ttl_reg;
    logic              cmd_valid;
    logic              cmd_ready;
    cmd_t              cmd;
    logic              rsp_valid;

    // Time-to-live register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ttl_reg <= TTL_RESET;
        else if (cfg_valid && cfg_ready)
            ttl_reg <= cfg_data;
    end

    tet_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tet_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ttl       (ttl_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_pop   (pop),
        .rsp       (rsp)
    );

    assign empty = !rsp_valid;

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import tet_pkg::*;

    // Request code with no operation behind it
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam int KEY_POOL_N = 96;
    localparam int QUIET_LIMIT = 4000;
    localparam int SCAN_CYCLES = ENTRIES + 3;

    logic clk = 1'b0;
    logic rst_n;
    logic push;
    logic full;
    req_t req_in;
    logic empty;
    logic pop = 1'b0;
    rsp_t rsp_out;
    logic cfg_valid;
    logic cfg_ready;
    logic [TIME_W-1:0] cfg_data;

    // Shadow of the token table and the time to live
    logic [KEY_W-1:0] tbl_key [ENTRIES];
    logic [EXP_W-1:0] tbl_exp [ENTRIES];
    bit tbl_used [ENTRIES];
    logic [TIME_W-1:0] ttl;

    // Replies owed by the block, oldest first
    rsp_t reply_q[$];
    logic [KEY_W-1:0] key_pool [KEY_POOL_N];
    int errors = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    token_expiry_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req_in),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Lowest valid slot holding key k, -1 if none
    function automatic int key_slot(input logic [KEY_W-1:0] k);
        int hit;
        hit = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (tbl_used[i] && tbl_key[i] == k)
                hit = i;
        return hit;
    endfunction

    // Apply one request to the shadow table and form its reply
    task automatic apply_req(input req_t r, output rsp_t a);
        int slot;
        logic [EXP_W-1:0] now_x;
        logic [EXP_W-1:0] expiry;
        a.live_count = '0;
        a.status = ST_DONE;
        now_x = {1'b0, r.now};
        expiry = now_x + {1'b0, ttl};
        case (r.req_type)
            REQ_GENERATE:
            begin
                slot = key_slot(r.token_key);
                // no match: lowest free or expired slot
                if (slot < 0)
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!tbl_used[i] || tbl_exp[i] <= now_x)
                            slot = i;
                if (slot < 0)
                    a.status = ST_FULL;
                else
                begin
                    tbl_key[slot] = r.token_key;
                    tbl_exp[slot] = expiry;
                    tbl_used[slot] = 1'b1;
                end
            end
            REQ_RENEW:
            begin
                slot = key_slot(r.token_key);
                if (slot >= 0 && tbl_exp[slot] > now_x)
                    tbl_exp[slot] = expiry;
                else
                    a.status = ST_IGNORED;
            end
            REQ_COUNT:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_used[i] && tbl_exp[i] > now_x && a.live_count < COUNT_MAX)
                        a.live_count++;
            end
            default: ;
        endcase
    endtask

    // Send one word; entered and left at a falling edge
    task automatic send_req(input req_t r);
        rsp_t want;
        push <= 1'b1;
        req_in <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        apply_req(r, want);
        reply_q.push_back(want);
        @(negedge clk);
    endtask

    task automatic issue(input logic [1:0] kind, input logic [KEY_W-1:0] k,
                         input logic [TIME_W-1:0] t);
        req_t r;
        r.req_type = kind;
        r.token_key = k;
        r.now = t;
        send_req(r);
    endtask

    // Hold the sender until every owed reply has been popped
    task automatic drain_replies();
        push <= 1'b0;
        @(negedge clk);
        while (reply_q.size() != 0)
            @(negedge clk);
    endtask

    // Write time to live while the block is idle
    task automatic set_ttl(input logic [TIME_W-1:0] v);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ttl = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Bursts of random length with random gaps, some short, some long enough to idle
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 5))
                0: gap = 0;
                1: gap = $urandom_range(60, 160);
                default: gap = $urandom_range(1, 24);
            endcase
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    // Random traffic over the key pool with time moving mostly forward
    task automatic random_phase(input logic [TIME_W-1:0] ttl_val,
                                input logic [TIME_W-1:0] start_now, input int step_max,
                                input int n_items, input bit pause_midway);
        req_t r;
        int pick;
        logic [TIME_W-1:0] t;
        set_ttl(ttl_val);
        t = start_now;
        for (int n = 0; n < n_items; n++)
        begin
            pace();
            if (pause_midway && n == n_items / 2)
                drain_replies();
            pick = $urandom_range(0, 99);
            if (pick < 50)
                r.req_type = REQ_GENERATE;
            else if (pick < 80)
                r.req_type = REQ_RENEW;
            else if (pick < 97)
                r.req_type = REQ_COUNT;
            else
                r.req_type = REQ_UNUSED;
            if ($urandom_range(0, 9) == 0)
                r.token_key = {$urandom, $urandom};
            else
                r.token_key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
            // now and then a short step back in time
            if ($urandom_range(0, 49) == 0)
                t = (t > 20) ? t - TIME_W'($urandom_range(1, 20)) : '0;
            else if (TIME_MAX - t > step_max)
                t = t + TIME_W'($urandom_range(0, step_max));
            else
                t = TIME_MAX;
            r.now = t;
            send_req(r);
        end
    endtask

    // Reset value of time to live, expiry boundary, renew misses, unused code
    task automatic test_reset_state();
        issue(REQ_COUNT, '0, '0);
        issue(REQ_GENERATE, '0, '0);
        issue(REQ_COUNT, KEY_ONES, '0);
        issue(REQ_RENEW, '0, '0);
        issue(REQ_COUNT, '0, 31'd1);
        issue(REQ_RENEW, '0, 31'd1);
        issue(REQ_GENERATE, '0, 31'd1);
        issue(REQ_RENEW, 64'd5, 31'd1);
        issue(REQ_UNUSED, KEY_ONES, TIME_MAX);
        issue(REQ_COUNT, '0, 31'd1);
    endtask

    // Largest time to live at the top of time, then time running backwards
    task automatic test_extremes();
        set_ttl(TIME_MAX);
        issue(REQ_GENERATE, KEY_ONES, TIME_MAX);
        issue(REQ_COUNT, '0, TIME_MAX);
        issue(REQ_RENEW, KEY_ONES, TIME_MAX);
        issue(REQ_COUNT, '0, '0);
        issue(REQ_GENERATE, {32{2'b01}}, '0);
        issue(REQ_GENERATE, {32{2'b10}}, {1'b0, {15{2'b10}}});
        issue(REQ_RENEW, {32{2'b01}}, {1'b1, {15{2'b01}}});
        issue(REQ_COUNT, KEY_ONES, {1'b1, {15{2'b01}}});
        issue(REQ_GENERATE, KEY_ONES, '0);
        issue(REQ_UNUSED, '0, '0);
        issue(REQ_COUNT, '0, TIME_MAX);
    endtask

    task automatic test_expiry_churn();
        random_phase(31'd1, 31'd2, 2, 400, 1'b0);
    endtask

    task automatic test_renew_window();
        random_phase(TIME_W'($urandom_range(100, 400)), 31'd100, 4, 400, 1'b1);
    endtask

    task automatic test_slot_reuse();
        random_phase(TIME_W'($urandom_range(1000, 100000)), 31'd5000, 500, 400, 1'b0);
    endtask

    task automatic test_table_full();
        random_phase(TIME_MAX, 31'd200000, 3, 400, 1'b0);
    endtask

    task automatic test_high_time();
        random_phase(TIME_W'($urandom_range(1, 32'h7FFF_FFFF)), TIME_MAX - 31'd4000, 16,
                     400, 1'b0);
    endtask

    // Receiver: pop pattern switches periodically among four modes
    always @(negedge clk)
    begin
        if (rx_cycle % 600 == 0)
            rx_mode = $urandom_range(0, 3);
        rx_cycle++;
        case (rx_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= (rx_cycle % 37) < 4;
            default: pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each popped word with the oldest owed reply
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && !empty && pop)
        begin
            if (reply_q.size() == 0)
            begin
                $error("unexpected result: live_count %0d, status %0d",
                       rsp_out.live_count, rsp_out.status);
                errors++;
            end
            else
            begin
                want = reply_q.pop_front();
                if (rsp_out.live_count !== want.live_count)
                begin
                    $error("live_count: expected %0d, actual %0d",
                           want.live_count, rsp_out.live_count);
                    errors++;
                end
                if (rsp_out.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_out.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        req_in = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        ttl = TTL_RESET;
        foreach (tbl_used[i])
            tbl_used[i] = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = KEY_ONES;
        for (int i = 2; i < KEY_POOL_N; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_extremes();
        test_expiry_churn();
        test_renew_window();
        test_slot_reuse();
        test_table_full();
        test_high_time();

        // wait out owed replies, then watch for stray results
        drain_replies();
        repeat (2 * SCAN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
